>>> src/fwt_pkg.sv
// Shared types, codes and sizes for the fragment window tracker.
package fwt_pkg;

  localparam int NUM_WINDOWS_DEF      = 4;
  localparam int MAX_WINDOW_TILES_DEF = 63;

  localparam int BITMAP_W = 63;
  localparam int WIN_W    = 2;
  localparam int WS_W     = 6;
  localparam int COUNT_W  = 8;

  localparam logic [1:0] OP_REGULAR = 2'd0;
  localparam logic [1:0] OP_ALL1    = 2'd1;

  localparam logic [2:0] KIND_IGNORED  = 3'd0;
  localparam logic [2:0] KIND_STORED   = 3'd1;
  localparam logic [2:0] KIND_ACK      = 3'd2;
  localparam logic [2:0] KIND_DECODE   = 3'd3;
  localparam logic [2:0] KIND_COMPOUND = 3'd4;
  localparam logic [2:0] KIND_REJECTED = 3'd5;

  typedef enum logic [1:0] {
    PH_RECEIVE      = 2'd0,
    PH_WAIT_ALL1    = 2'd1,
    PH_WAIT_MISSING = 2'd2,
    PH_END          = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_EMIT,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] window_index;
    logic [5:0] fcn;
    logic [5:0] tile_count;
    logic [7:0] k_symbols;
  } item_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [WIN_W-1:0]    report_window;
    logic [BITMAP_W-1:0] window_bitmap;
    logic [COUNT_W-1:0]  columns_received;
    logic [COUNT_W-1:0]  next_tile;
    logic                last_of_run;
  } res_t;

endpackage

>>> src/fragment_window_tracker_top.sv
// Fragment window tracker: tile bitmaps, column map and ack generation.
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_we                  cfg_wdata (window size)
//   item      in         item_valid/item_ready   item (item_t)
//   res       out        res_valid/res_ready     res (res_t)
//
// After reset a clearing pass zeroes the column map one entry per cycle, with item_ready
// low; the rest clears at once. One request is in work at a time, taken in the idle state.
// A regular fragment marks one tile per cycle, then makes the ack decision and loads the
// result. An All-1 with too few columns walks one window per cycle; an All-1 with enough
// columns, and ignored or rejected requests, go straight to loading their result.
// A stalled result register holds the sequencer in its emitting or walking step.
module fragment_window_tracker_top
  import fwt_pkg::*;
#(
  parameter int NUM_WINDOWS      = NUM_WINDOWS_DEF,
  parameter int MAX_WINDOW_TILES = MAX_WINDOW_TILES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [WS_W-1:0] cfg_wdata,
  input  logic            item_valid,
  output logic            item_ready,
  input  item_t           item,
  output logic            res_valid,
  input  logic            res_ready,
  output res_t            res
);

  localparam int COL_SLOTS = NUM_WINDOWS * MAX_WINDOW_TILES;
  localparam int COL_IDX_W = (COL_SLOTS > 1) ? $clog2(COL_SLOTS) : 1;
  localparam int WIN_IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
  localparam logic [WS_W-1:0]    MAX_WS    = WS_W'(MAX_WINDOW_TILES);
  localparam logic [2:0]         WIN_LIMIT = 3'(NUM_WINDOWS);
  localparam logic [COUNT_W-1:0] COL_MAX   = COUNT_W'(COL_SLOTS);
  localparam logic [COL_IDX_W-1:0] CLR_LAST = COL_IDX_W'(COL_SLOTS - 1);

  // Session state.
  logic [WS_W-1:0]     window_size;
  logic [BITMAP_W-1:0] bitmaps [NUM_WINDOWS];
  logic                column_seen [COL_SLOTS];
  logic [COUNT_W-1:0]  seen_count;
  logic [COUNT_W-1:0]  tile_high_mark;
  logic [WIN_W-1:0]    final_window;
  logic [COUNT_W-1:0]  needed_symbols;
  phase_t              phase;

  // Sequencer and the tile cursor it steps.
  state_t              state, state_next;
  logic [2:0]          pend_kind;
  logic [COUNT_W-1:0]  pos;
  logic [5:0]          remaining;
  logic [WS_W-1:0]     cur_off;
  logic [WIN_W-1:0]    cur_win;
  logic [WIN_W-1:0]    walk_idx;
  logic [COL_IDX_W-1:0] clr_addr;
  logic                clear_done;

  // Effective window size and the derived limits.
  logic [WS_W-1:0]     ws;
  logic [COUNT_W-1:0]  limit;
  logic [BITMAP_W-1:0] full_mask;

  assign ws = (window_size == '0) ? WS_W'(1) :
              (window_size > MAX_WS) ? MAX_WS : window_size;
  assign limit     = COUNT_W'(NUM_WINDOWS * ws);
  assign full_mask = {BITMAP_W{1'b1}} >> (BITMAP_W - ws);
  assign clear_done = clr_addr == CLR_LAST;

  // Request classification, done in the cycle the request is taken.
  logic                accept;
  logic                drop_item;
  logic                bad_item;
  logic [WIN_W-1:0]    item_win;
  logic [WS_W-1:0]     start_off;
  logic [COUNT_W-1:0]  win_base;
  logic [COUNT_W-1:0]  base;
  logic [COUNT_W:0]    span_end;
  logic [COUNT_W-1:0]  end_clamp;
  logic                enough;

  assign accept    = item_valid && item_ready;
  assign drop_item = (phase != PH_RECEIVE) || ((item.op != OP_REGULAR) && (item.op != OP_ALL1));
  assign bad_item  = (item.window_index >= WIN_LIMIT) ||
                     ((item.op == OP_REGULAR) && (item.fcn >= ws));
  assign item_win  = item.window_index[WIN_W-1:0];
  assign start_off = ws - WS_W'(1) - item.fcn;
  assign win_base  = COUNT_W'(item_win) * COUNT_W'(ws);
  assign base      = win_base + COUNT_W'(start_off);
  assign span_end  = {1'b0, base} + (COUNT_W+1)'(item.tile_count);
  assign end_clamp = (span_end > {1'b0, limit}) ? limit : span_end[COUNT_W-1:0];
  assign enough    = seen_count >= needed_symbols;

  // One tile step of the marking loop. col_rd holds the column map entry at pos;
  // it is read on acceptance for the first tile and one tile ahead while marking.
  logic mark_done;
  logic col_rd;

  assign mark_done = (remaining == '0) || (pos >= limit);

  // Column map port control: the clearing pass writes zeros, marking writes ones.
  logic                 col_we;
  logic                 col_wbit;
  logic [COL_IDX_W-1:0] col_waddr;
  logic                 col_re;
  logic [COUNT_W-1:0]   col_raddr;

  assign col_we    = (state == ST_CLEAR) || ((state == ST_MARK) && !mark_done && !col_rd);
  assign col_wbit  = state != ST_CLEAR;
  assign col_waddr = (state == ST_CLEAR) ? clr_addr : pos[COL_IDX_W-1:0];
  assign col_raddr = (state == ST_MARK) ? pos + COUNT_W'(1) : base;
  assign col_re    = (((state == ST_IDLE) && accept) || ((state == ST_MARK) && !mark_done)) &&
                     (col_raddr < COL_MAX);

  // One window step of the compound ack walk.
  logic [BITMAP_W-1:0] walk_bm;
  logic                walk_last;
  logic                walk_hit;
  logic                slot_free;

  assign walk_bm   = bitmaps[walk_idx[WIN_IDX_W-1:0]];
  assign walk_last = walk_idx == final_window;
  assign walk_hit  = walk_last || ((walk_bm & full_mask) != full_mask);
  assign slot_free = !res_valid || res_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (drop_item || bad_item) begin
            state_next = ST_EMIT;
          end else if (item.op == OP_REGULAR) begin
            state_next = ST_MARK;
          end else if (enough) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_MARK: begin
        if (mark_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_WALK: begin
        if (walk_last && slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  logic             emit;
  logic [2:0]       emit_kind;
  logic [WIN_W-1:0] emit_win;
  logic             emit_last;
  logic             walk_step;

  always_comb begin
    item_ready = 1'b0;
    emit       = 1'b0;
    emit_kind  = pend_kind;
    emit_win   = final_window;
    emit_last  = 1'b1;
    walk_step  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
      end
      ST_IDLE: item_ready = 1'b1;
      ST_MARK: begin
      end
      ST_EMIT: emit = slot_free;
      ST_WALK: begin
        emit      = walk_hit && slot_free;
        emit_kind = KIND_COMPOUND;
        emit_win  = walk_idx;
        emit_last = walk_last;
        walk_step = !walk_hit || slot_free;
      end
      default: begin
      end
    endcase
  end

  // Received-column map: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (col_we) column_seen[col_waddr] <= col_wbit;
    if (col_re) col_rd <= column_seen[col_raddr[COL_IDX_W-1:0]];
  end

  // Session state and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      window_size    <= MAX_WS;
      seen_count     <= '0;
      tile_high_mark <= '0;
      final_window   <= '0;
      needed_symbols <= '0;
      phase          <= PH_RECEIVE;
      res_valid      <= 1'b0;
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        bitmaps[w] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) window_size <= cfg_wdata;

      if (state == ST_CLEAR) clr_addr <= clr_addr + COL_IDX_W'(1);

      if (state == ST_IDLE && accept && !drop_item && !bad_item) begin
        if (item.op == OP_REGULAR) begin
          if (item_win > final_window) final_window <= item_win;
          needed_symbols <= item.k_symbols;
          if (end_clamp > tile_high_mark) tile_high_mark <= end_clamp;
        end else begin
          // All-1: the last tile of its window counts as received.
          final_window <= item_win;
          bitmaps[item_win[WIN_IDX_W-1:0]][ws - WS_W'(1)] <= 1'b1;
          phase <= enough ? PH_END : PH_WAIT_MISSING;
        end
      end

      if (state == ST_MARK) begin
        if (mark_done) begin
          if (enough) phase <= PH_WAIT_ALL1;
        end else begin
          bitmaps[cur_win[WIN_IDX_W-1:0]][cur_off] <= 1'b1;
          if (!col_rd) seen_count <= seen_count + COUNT_W'(1);
        end
      end

      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Cursor, pending result code and result payload.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      walk_idx <= '0;
      if (drop_item) begin
        pend_kind <= KIND_IGNORED;
      end else if (bad_item) begin
        pend_kind <= KIND_REJECTED;
      end else if (item.op == OP_REGULAR) begin
        pos       <= base;
        remaining <= item.tile_count;
        cur_off   <= start_off;
        cur_win   <= item_win;
      end else begin
        pend_kind <= KIND_DECODE;
      end
    end

    if (state == ST_MARK) begin
      if (mark_done) begin
        pend_kind <= enough ? KIND_ACK : KIND_STORED;
      end else begin
        // Step to the next tile, spilling into the next window at its end.
        pos       <= pos + COUNT_W'(1);
        remaining <= remaining - 6'd1;
        if (cur_off == ws - WS_W'(1)) begin
          cur_off <= '0;
          cur_win <= cur_win + WIN_W'(1);
        end else begin
          cur_off <= cur_off + WS_W'(1);
        end
      end
    end

    if (walk_step) walk_idx <= walk_idx + WIN_W'(1);

    if (emit) begin
      res.kind             <= emit_kind;
      res.report_window    <= emit_win;
      res.window_bitmap    <= bitmaps[emit_win[WIN_IDX_W-1:0]];
      res.columns_received <= seen_count;
      res.next_tile        <= tile_high_mark;
      res.last_of_run      <= emit_last;
    end
  end

  // The marking cursor never leaves the windows that exist.
  a_cursor_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && !mark_done) |-> ({1'b0, cur_win} < WIN_LIMIT))
    else $error("marking cursor ran past the last window");

  // The distinct column count is bounded by the column map size.
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= COL_MAX)
    else $error("column count exceeds the column map");

  // The compound ack walk stops at the final window.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (walk_idx <= final_window))
    else $error("compound ack walk passed the final window");

  // Once the session has ended it stays ended until reset.
  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(phase) == PH_END) |-> (phase == PH_END))
    else $error("session left the end phase");

endmodule

>>> dv/fragment_window_tracker_top_tb.sv
// Self-checking testbench for the fragment window tracker against a built-in tracking model.
`timescale 1ns / 1ps

module fragment_window_tracker_top_tb;
  import fwt_pkg::*;

  // Fragment kinds that the tracker must ignore.
  localparam logic [1:0] OP_OTHER = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int NWIN         = NUM_WINDOWS_DEF;
  localparam int HOLD_CYCLES  = 200;
  localparam int DOG_LIMIT    = 3000;
  localparam int TAIL_CYCLES  = 80;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        res_valid;
  logic        res_ready;
  res_t        res;

  fragment_window_tracker_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow copy of the tracker's session state. It is advanced once per
  // accepted request, in acceptance order, so it always reflects the state
  // the block sees when it starts on the next request.
  logic [62:0] win_map [NWIN];
  bit          col_map [NWIN * MAX_WINDOW_TILES_DEF];
  int          seen_cols;
  int          high_mark;
  int          final_win;
  int          need_k;
  phase_t      sess_phase;
  logic [5:0]  ws_reg;

  res_t        pending_reports [$];
  res_t        want;
  int          errors;
  int          sent_count;
  int          checked_count;
  int          quiet_cycles;
  bit          gaps_on;
  bit          hold_requested;
  string       close_path;

  task automatic reset_tracker();
    int i;
    for (i = 0; i < NWIN; i++) win_map[i] = '0;
    for (i = 0; i < NWIN * MAX_WINDOW_TILES_DEF; i++) col_map[i] = 1'b0;
    seen_cols  = 0;
    high_mark  = 0;
    final_win  = 0;
    need_k     = 0;
    sess_phase = PH_RECEIVE;
    ws_reg     = 6'd63;
  endtask

  // A window size of zero behaves as one tile per window.
  function automatic int window_tiles();
    return (ws_reg == 6'd0) ? 1 : int'(ws_reg);
  endfunction

  function automatic void push_report(logic [2:0] kind, int win, bit last);
    res_t r;
    r.kind             = kind;
    r.report_window    = win[WIN_W-1:0];
    r.window_bitmap    = win_map[win];
    r.columns_received = seen_cols[7:0];
    r.next_tile        = high_mark[7:0];
    r.last_of_run      = last;
    pending_reports = {pending_reports, r};
  endfunction

  // Advances the shadow state by one request and queues the reports it causes.
  function automatic void track_fragment(item_t it);
    int ws;
    int lim;
    int base;
    int p;
    int stop;
    int i;
    logic [63:0] full;
    int missing [$];
    ws  = window_tiles();
    lim = NWIN * ws;
    if (sess_phase != PH_RECEIVE || it.op > OP_ALL1) begin
      push_report(KIND_IGNORED, final_win, 1'b1);
      return;
    end
    if (it.window_index >= NWIN || (it.op == OP_REGULAR && it.fcn >= ws)) begin
      push_report(KIND_REJECTED, final_win, 1'b1);
      return;
    end
    if (it.op == OP_REGULAR) begin
      // FCN counts down, so the first tile sits fcn places before the window's end.
      base = (int'(it.window_index) + 1) * ws - 1 - int'(it.fcn);
      if (int'(it.window_index) > final_win) final_win = int'(it.window_index);
      need_k = int'(it.k_symbols);
      for (i = 0; i < int'(it.tile_count); i++) begin
        p = base + i;
        if (p >= lim) break;
        win_map[p / ws][p % ws] = 1'b1;
        if (!col_map[p]) begin
          col_map[p] = 1'b1;
          seen_cols++;
        end
      end
      stop = base + int'(it.tile_count);
      if (stop > lim) stop = lim;
      if (stop > high_mark) high_mark = stop;
      if (seen_cols >= need_k) begin
        sess_phase = PH_WAIT_ALL1;
        push_report(KIND_ACK, final_win, 1'b1);
      end else begin
        push_report(KIND_STORED, final_win, 1'b1);
      end
      return;
    end
    // All-1 fragment: it always carries the last tile of its window.
    final_win = int'(it.window_index);
    win_map[final_win][ws - 1] = 1'b1;
    if (seen_cols >= need_k) begin
      sess_phase = PH_END;
      push_report(KIND_DECODE, final_win, 1'b1);
      return;
    end
    full = (64'd1 << ws) - 64'd1;
    for (i = 0; i < final_win; i++) begin
      if ((win_map[i] & full[62:0]) != full[62:0]) missing = {missing, i};
    end
    missing = {missing, final_win};
    sess_phase = PH_WAIT_MISSING;
    for (i = 0; i < missing.size(); i++) begin
      push_report(KIND_COMPOUND, missing[i], i == missing.size() - 1);
    end
  endfunction

  // Distinct columns the session would hold after this regular fragment.
  function automatic int columns_after(item_t it);
    int ws;
    int lim;
    int base;
    int p;
    int i;
    int n;
    ws = window_tiles();
    lim = NWIN * ws;
    n = seen_cols;
    if (it.window_index >= NWIN || it.fcn >= ws) return n;
    base = (int'(it.window_index) + 1) * ws - 1 - int'(it.fcn);
    for (i = 0; i < int'(it.tile_count); i++) begin
      p = base + i;
      if (p >= lim) break;
      if (!col_map[p]) n++;
    end
    return n;
  endfunction

  // A needed-symbol count that stays out of reach keeps the session open,
  // since any ack or All-1 ends it for good and reset comes only once.
  function automatic logic [7:0] open_k(item_t it);
    return 8'($urandom_range(columns_after(it) + 1, 255));
  endfunction

  function automatic item_t random_fragment();
    item_t it;
    int ws;
    int pick;
    ws = window_tiles();
    pick = $urandom_range(0, 99);
    it.op           = OP_REGULAR;
    it.window_index = 3'($urandom_range(0, NWIN - 1));
    it.fcn          = 6'($urandom_range(0, ws - 1));
    it.tile_count   = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(1, 6));
    it.k_symbols    = 8'($urandom_range(0, 255));
    // Most traffic is well-formed regular fragments; the rest is other kinds, bad windows
    // or a random fcn, ignored or rejected without touching the session unless the fcn fits.
    if (pick >= 90) begin
      it.op = 2'($urandom_range(OP_OTHER, OP_SPARE));
    end else if (pick >= 84) begin
      it.op = 2'($urandom_range(OP_REGULAR, OP_ALL1));
      it.window_index = 3'($urandom_range(NWIN, 7));
    end else if (pick >= 78) begin
      it.fcn = 6'($urandom_range(0, 63));
    end
    if (it.op == OP_REGULAR) it.k_symbols = open_k(it);
    return it;
  endfunction

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_fragment(item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    track_fragment(it);
    sent_count++;
  endtask

  task automatic send_regular(int win, int fcn, int tiles, int k);
    item_t it;
    it.op           = OP_REGULAR;
    it.window_index = 3'(win);
    it.fcn          = 6'(fcn);
    it.tile_count   = 6'(tiles);
    it.k_symbols    = 8'(k);
    send_fragment(it);
  endtask

  task automatic send_other(logic [1:0] op, int win);
    item_t it;
    it.op           = op;
    it.window_index = 3'(win);
    it.fcn          = 6'($urandom_range(0, 63));
    it.tile_count   = 6'($urandom_range(0, 63));
    it.k_symbols    = 8'($urandom_range(0, 255));
    send_fragment(it);
  endtask

  // Waits until every queued report has come back and the block is idle.
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window_size(logic [5:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ws_reg = v;
  endtask

  task automatic run_random(int n);
    int i;
    for (i = 0; i < n; i++) send_fragment(random_fragment());
  endtask

  // Window size 63 from reset: ignored kinds, every rejection, full window,
  // duplicates, spill into the next window and tiles past the last window.
  task automatic test_directed_fragments();
    send_other(OP_OTHER, 0);
    send_other(OP_SPARE, 7);
    send_other(OP_REGULAR, 4);
    send_other(OP_ALL1, 7);
    send_regular(1, 63, 5, 255);
    send_regular(1, 62, 63, 255);
    send_regular(1, 62, 63, 255);
    send_regular(2, 1, 5, 255);
    send_regular(3, 0, 63, 255);
    send_regular(2, 30, 0, 255);
    send_regular(0, 0, 1, 254);
  endtask

  // Size zero must act as one; going back to 63 reinterprets the stored bitmaps.
  task automatic test_window_size_extremes();
    set_window_size(6'd0);
    send_regular(0, 0, 1, 255);
    send_regular(3, 0, 2, 255);
    send_regular(1, 1, 1, 255);
    set_window_size(6'd63);
    send_regular(0, 10, 3, 255);
    set_window_size(6'd1);
    send_regular(2, 0, 1, 255);
  endtask

  task automatic test_random_traffic();
    set_window_size(6'd1);
    run_random(40);
    set_window_size(6'd4);
    run_random(50);
    set_window_size(6'd63);
    run_random(70);
  endtask

  // The receiver stops taking results for a long stretch while requests keep
  // coming, so the result register fills and the input side must stall.
  task automatic test_input_backpressure();
    set_window_size(6'($urandom_range(2, 62)));
    gaps_on = 1'b0;
    hold_requested = 1'b1;
    run_random(25);
    gaps_on = 1'b1;
  endtask

  // Final stretch runs without any idling on either side. The session is then
  // closed either by an ack or by an All-1 that draws a compound ack; after
  // that every request must be ignored. Decode-ready needs an All-1 ahead of
  // any regular fragment, which would close the session at once.
  task automatic test_session_close();
    item_t it;
    int i;
    set_window_size(6'($urandom_range(2, 62)));
    gaps_on = 1'b0;
    run_random(40);
    if ($urandom_range(0, 2) != 0) begin
      close_path = "compound ack";
      it.op           = OP_ALL1;
      it.window_index = 3'(($urandom_range(0, 1) != 0) ? NWIN - 1
                                                       : $urandom_range(0, NWIN - 1));
      it.fcn          = 6'($urandom_range(0, 63));
      it.tile_count   = 6'($urandom_range(0, 63));
      it.k_symbols    = 8'($urandom_range(0, 255));
    end else begin
      close_path = "symbol ack";
      it.op           = OP_REGULAR;
      it.window_index = 3'($urandom_range(0, NWIN - 1));
      it.fcn          = 6'($urandom_range(0, window_tiles() - 1));
      it.tile_count   = 6'($urandom_range(0, 63));
      it.k_symbols    = 8'(($urandom_range(0, 1) != 0) ? 0
                                                       : $urandom_range(0, columns_after(it)));
    end
    send_fragment(it);
    for (i = 0; i < 6; i++) begin
      it = random_fragment();
      it.op = 2'(i % 4);
      it.window_index = 3'($urandom_range(0, 7));
      send_fragment(it);
    end
  endtask

  // Result side: random stalls in short bursts, or one long hold on request.
  initial begin
    res_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        res_ready <= 1'b1;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(string what, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
    end
  endfunction

  // Every accepted result is matched against the oldest queued report.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request behind it, expected none, actual kind %0d",
                 $time, res.kind);
      end else begin
        want = pending_reports.pop_front();
        compare_field("kind", 64'(want.kind), 64'(res.kind));
        compare_field("report_window", 64'(want.report_window), 64'(res.report_window));
        compare_field("window_bitmap", 64'(want.window_bitmap), 64'(res.window_bitmap));
        compare_field("columns_received", 64'(want.columns_received),
                      64'(res.columns_received));
        compare_field("next_tile", 64'(want.next_tile), 64'(res.next_tile));
        compare_field("last_of_run", 64'(want.last_of_run), 64'(res.last_of_run));
        checked_count++;
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (res_valid && res_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= DOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_reports.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    item_valid     = 1'b0;
    item           = '0;
    gaps_on        = 1'b1;
    hold_requested = 1'b0;
    errors         = 0;
    sent_count     = 0;
    checked_count  = 0;
    quiet_cycles   = 0;
    close_path     = "";
    reset_tracker();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_fragments();
    test_window_size_extremes();
    test_random_traffic();
    test_input_backpressure();
    test_session_close();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d results, window sizes 0, 1, 4, 63 and two",
             sent_count, checked_count);
    $display("random sizes, a long result stall, and a session closed by %s.", close_path);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
